### rtl/circular_list_with_elimination_assert.svh
`ifndef CIRCULAR_LIST_WITH_ELIMINATION_ASSERT_SVH
`define CIRCULAR_LIST_WITH_ELIMINATION_ASSERT_SVH

// Checks that are switched off while reset is high.
`define CLE_ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that hold at every edge, reset included.
`define CLE_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cle_pkg.sv
package cle_pkg;

   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_ELIM   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int ValueWidth = 32;
   localparam int IndexWidth = 16;
   localparam int CountWidth = 7;

endpackage

### rtl/circular_list_with_elimination.sv
// A bounded circular list of signed values held in one RAM, addressed through
// a moving top pointer. Push and any command on an empty list are answered
// straight from idle. Remove and read wait on the bit-serial modulo unit, and
// a remove then closes up the list entry by entry behind the removed one,
// since the list is closed up through the single RAM read port. Eliminate runs
// one modulo and one close-up per removed entry, then reads out the survivor.
// Busy stays high until the result strobe; the result is shown for one cycle
// and cannot be held off.
`include "circular_list_with_elimination_assert.svh"

module circular_list_with_elimination #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_item_value,
   input  logic [15:0]        req_position,
   input  logic [15:0]        req_step_count,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]         rsp_entry_count,
   output logic [1:0]         rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_ADD, ST_READ, ST_RWAIT, ST_SHIFT, ST_SWR, ST_ELIM
   } state_type;

   state_type         state_ff;
   logic [1:0]        mode_ff;
   logic [15:0]       step_ff;
   logic [15:0]       div_ff;
   logic [CW-1:0]     rem_ff;
   logic [3:0]        bit_ff;
   logic [AW-1:0]     cur_ff;
   logic [AW-1:0]     j_ff;
   logic [AW-1:0]     head_ff;
   logic [CW-1:0]     occ_ff;
   logic [31:0]       value_ff;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_value_ff;
   logic [6:0]        rsp_count_ff;
   logic [1:0]        rsp_status_ff;

   logic [CW:0]       shift_in;
   logic [CW-1:0]     rem_in;
   logic [CW:0]       sum_in;
   logic [AW-1:0]     idx_in;
   logic [AW-1:0]     head_dec_in;
   logic              more_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [31:0]       wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [31:0]       rd_data;

   function automatic logic [AW-1:0] phys_f(input logic [AW-1:0] h, input logic [AW-1:0] i);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, i};
      if (s >= (AW + 1)'(DEPTH)) begin
         s = s - (AW + 1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   always_comb begin
      shift_in = {rem_ff, div_ff[15]};
      if (shift_in >= {1'b0, occ_ff}) begin
         rem_in = CW'(shift_in - {1'b0, occ_ff});
      end else begin
         rem_in = CW'(shift_in);
      end
      sum_in = (CW + 1)'(cur_ff) + (CW + 1)'(rem_ff);
      if (sum_in >= {1'b0, occ_ff}) begin
         idx_in = AW'(sum_in - {1'b0, occ_ff});
      end else begin
         idx_in = AW'(sum_in);
      end
      head_dec_in = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
      more_in = (32'(j_ff) + 32'd1) < 32'(occ_ff);
   end

   always_comb begin
      wr_en = (state_ff == ST_SWR) ||
              (state_ff == ST_IDLE && start && req_mode == cle_pkg::MODE_PUSH &&
               32'(occ_ff) < DEPTH);
      wr_addr = (state_ff == ST_SWR) ? phys_f(head_ff, j_ff) : head_dec_in;
      wr_data = (state_ff == ST_SWR) ? rd_data : req_item_value;
      rd_en   = (state_ff == ST_READ) || (state_ff == ST_SHIFT);
      rd_addr = (state_ff == ST_READ) ? phys_f(head_ff, cur_ff)
                                      : phys_f(head_ff, j_ff + AW'(1));
   end

   cle_ram #(.WIDTH(cle_pkg::ValueWidth), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  mode_ff <= req_mode;
                  step_ff <= req_step_count;
                  div_ff  <= req_position;
                  rem_ff  <= '0;
                  bit_ff  <= '0;
                  cur_ff  <= '0;
                  if (req_mode == cle_pkg::MODE_PUSH) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_value_ff <= '0;
                     if (32'(occ_ff) >= DEPTH) begin
                        rsp_count_ff  <= 7'(occ_ff);
                        rsp_status_ff <= cle_pkg::STATUS_FULL;
                     end else begin
                        head_ff       <= head_dec_in;
                        occ_ff        <= occ_ff + CW'(1);
                        rsp_count_ff  <= 7'(occ_ff + CW'(1));
                        rsp_status_ff <= cle_pkg::STATUS_OK;
                     end
                  end else if (occ_ff == '0) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_value_ff  <= '0;
                     rsp_count_ff  <= '0;
                     rsp_status_ff <= cle_pkg::STATUS_EMPTY;
                  end else if (req_mode == cle_pkg::MODE_ELIM) begin
                     state_ff <= ST_ELIM;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               div_ff <= {div_ff[14:0], 1'b0};
               rem_ff <= rem_in;
               bit_ff <= bit_ff + 4'd1;
               if (bit_ff == 4'd15) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               cur_ff   <= idx_in;
               j_ff     <= idx_in;
               state_ff <= (mode_ff == cle_pkg::MODE_ELIM) ? ST_SHIFT : ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_RWAIT;
            end
            ST_RWAIT: begin
               value_ff <= rd_data;
               if (mode_ff == cle_pkg::MODE_REMOVE) begin
                  state_ff <= ST_SHIFT;
               end else begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= rd_data;
                  rsp_count_ff  <= 7'(occ_ff);
                  rsp_status_ff <= cle_pkg::STATUS_OK;
                  if (mode_ff == cle_pkg::MODE_ELIM) begin
                     head_ff <= phys_f(head_ff, cur_ff);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_SHIFT: begin
               if (more_in) begin
                  state_ff <= ST_SWR;
               end else begin
                  occ_ff <= occ_ff - CW'(1);
                  if (mode_ff == cle_pkg::MODE_REMOVE) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_value_ff  <= value_ff;
                     rsp_count_ff  <= 7'(occ_ff - CW'(1));
                     rsp_status_ff <= cle_pkg::STATUS_OK;
                     state_ff      <= ST_IDLE;
                  end else begin
                     if (CW'(cur_ff) >= occ_ff - CW'(1)) begin
                        cur_ff <= '0;
                     end
                     state_ff <= ST_ELIM;
                  end
               end
            end
            ST_SWR: begin
               j_ff     <= j_ff + AW'(1);
               state_ff <= ST_SHIFT;
            end
            ST_ELIM: begin
               if (occ_ff > CW'(1)) begin
                  div_ff   <= step_ff;
                  rem_ff   <= '0;
                  bit_ff   <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   `CLE_ASSERT_RST(a_occ_bound, clock, reset, 32'(occ_ff) <= DEPTH, "Entry count exceeds depth.")
   `CLE_ASSERT_RST(a_done_responds, clock, reset, $fell(busy) |-> rsp_valid,
      "Transaction finished without a result.")
   `CLE_ASSERT_RST(a_error_zero, clock, reset,
      (rsp_valid && rsp_status != cle_pkg::STATUS_OK) |-> (rsp_read_value == 32'sd0),
      "Error result carries a nonzero value.")
   `CLE_ASSERT_RST(a_cur_in_range, clock, reset,
      (state_ff == ST_READ) |-> (CW'(cur_ff) < occ_ff),
      "Read index lies beyond the entry count.")

endmodule

### rtl/cle_ram.sv
module cle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
